FILE: sv/tkm_pkg.sv
package tkm_pkg;

  localparam int NODES    = 256;
  localparam int ALPHABET = 128;
  localparam int CHAR_W   = 8;
  localparam int ID_W     = 8;
  localparam int NODE_W   = $clog2(NODES);
  localparam int CH_W     = $clog2(ALPHABET);
  localparam int SLOTS    = NODES * ALPHABET;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int KEY_W    = ID_W + 1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_MATCH  = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [KEY_W-1:0]  key_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;
    logic take;
    logic lookup;
    logic key_wr;
    logic load_ins;
    logic load_match;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic skip;
    logic in_last;
    logic last;
    logic is_match;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/tkm_in_if.sv
interface tkm_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [tkm_pkg::CHAR_W-1:0] ch;
  logic                      last;
  logic [tkm_pkg::ID_W-1:0]   key_id;

  modport source (output valid, output cmd, output ch, output last, output key_id,
                  input ready);
  modport sink (input valid, input cmd, input ch, input last, input key_id,
                output ready);
endinterface

FILE: sv/tkm_out_if.sv
interface tkm_out_if;
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [tkm_pkg::ID_W-1:0] matched_id;
  logic                    table_full;

  modport source (output valid, output found, output matched_id, output table_full,
                  input ready);
  modport sink (input valid, input found, input matched_id, input table_full,
                output ready);
endinterface

FILE: sv/tkm_ctrl.sv
module tkm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tkm_pkg::sts_t sts,
  output tkm_pkg::ctl_t ctl
);
  import tkm_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_FINISH,
    ST_REPORT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        ctl.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.take = 1'b1;
          // a broken path or an out-of-alphabet character needs no table read
          if (!sts.skip) begin
            state_next = ST_LOOK;
          end else if (sts.in_last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_LOOK: begin
        ctl.lookup = 1'b1;
        state_next = sts.last ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (sts.is_match) begin
          state_next = ST_REPORT;
        end else if (sts.out_free) begin
          ctl.key_wr   = 1'b1;
          ctl.load_ins = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          ctl.load_match = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/tkm_datapath.sv
module tkm_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  tkm_pkg::ctl_t             ctl,
  output tkm_pkg::sts_t             sts,
  input  logic                      cmd,
  input  logic [tkm_pkg::CHAR_W-1:0] ch,
  input  logic                      last,
  input  logic [tkm_pkg::ID_W-1:0]   key_id,
  tkm_out_if.source                 results
);
  import tkm_pkg::*;

  node_t child_mem [SLOTS];
  key_t  key_mem [NODES];

  node_t           child_rdata;
  key_t            key_rdata;
  slot_t           clr_addr;
  node_t           cursor;
  node_t           nodes_used;
  logic            broken;
  logic            cmd_q;
  logic            last_q;
  logic [ID_W-1:0] id_q;
  slot_t           slot_q;

  logic            ch_oob;
  slot_t           slot;
  logic            room;
  node_t           new_node;
  logic            key_hit;

  assign ch_oob   = {1'b0, ch} >= (CHAR_W + 1)'(ALPHABET);
  assign slot     = SLOT_W'(cursor) * SLOT_W'(ALPHABET) + SLOT_W'(ch[CH_W-1:0]);
  assign room     = ((NODE_W + 1)'(nodes_used) + (NODE_W + 1)'(1)) < (NODE_W + 1)'(NODES);
  assign new_node = nodes_used + node_t'(1);
  assign key_hit  = !broken && key_rdata[ID_W];

  assign sts.clr_last = clr_addr == SLOT_W'(SLOTS - 1);
  assign sts.skip     = broken || ch_oob;
  assign sts.in_last  = last;
  assign sts.last     = last_q;
  assign sts.is_match = cmd_q == CMD_MATCH;
  assign sts.out_free = !results.valid || results.ready;

  // child table: one write port, one registered read at the incoming slot
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      child_mem[clr_addr] <= '0;
    end else if (ctl.lookup && child_rdata == '0 && cmd_q == CMD_INSERT && room) begin
      child_mem[slot_q] <= new_node;
    end
    child_rdata <= child_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      if (clr_addr < SLOT_W'(NODES)) begin
        key_mem[clr_addr[NODE_W-1:0]] <= '0;
      end
    end else if (ctl.key_wr && !broken) begin
      key_mem[cursor] <= {1'b1, id_q};
    end
    key_rdata <= key_mem[cursor];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      cursor     <= '0;
      nodes_used <= '0;
      broken     <= 1'b0;
    end else begin
      if (ctl.clr) begin
        clr_addr <= clr_addr + slot_t'(1);
      end
      if (ctl.take && !broken && ch_oob) begin
        broken <= 1'b1;
      end
      if (ctl.lookup) begin
        priority if (child_rdata != '0) begin
          cursor <= child_rdata;
        end else if (cmd_q == CMD_INSERT && room) begin
          nodes_used <= new_node;
          cursor     <= new_node;
        end else begin
          broken <= 1'b1;
        end
      end
      // end of key: back to the root
      if (ctl.load_ins || ctl.load_match) begin
        cursor <= '0;
        broken <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_q  <= cmd;
      last_q <= last;
      id_q   <= key_id;
      slot_q <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (ctl.load_ins || ctl.load_match) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_ins) begin
      results.found      <= 1'b0;
      results.matched_id <= '0;
      results.table_full <= broken;
    end else if (ctl.load_match) begin
      results.found      <= key_hit;
      results.matched_id <= key_hit ? key_rdata[ID_W-1:0] : '0;
      results.table_full <= 1'b0;
    end
  end

endmodule

FILE: sv/trie_keyword_matcher.sv
// Trie keyword matcher: keys arrive one character per transfer on keys (cmd 0 inserts,
// cmd 1 matches, last ends the key) and one result transfer on results follows each
// last character. A character takes the registered read of the child table, then the
// cursor update or node allocation; a last character adds the id-table access, a
// write on insert and a registered read on match. Characters on a broken path skip
// the table read. After reset the block clears the child and id tables in a pass
// over all NODES * ALPHABET slots (32768) and holds keys.ready low meanwhile.
module trie_keyword_matcher (
  input  logic      clk,
  input  logic      rst,
  tkm_in_if.sink    keys,
  tkm_out_if.source results
);
  import tkm_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic in_ready;

  tkm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (keys.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  assign keys.ready = in_ready;

  tkm_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sts     (sts),
    .cmd     (keys.cmd),
    .ch      (keys.ch),
    .last    (keys.last),
    .key_id  (keys.key_id),
    .results (results)
  );

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.clr |-> !keys.ready)
    else $error("key transfer possible during table clear");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.load_ins || ctl.load_match) |-> (!results.valid || results.ready))
    else $error("result loaded over a pending result");

  a_ready_after_char: assert property (@(posedge clk) disable iff (rst)
    (ctl.lookup && !sts.last) |=> keys.ready)
    else $error("not ready after a non-final character");

endmodule

FILE: sim/trie_keyword_matcher_tb.sv
`timescale 1ns / 1ps

module trie_keyword_matcher_tb;
  import tkm_pkg::*;

  localparam int GAP_MAX      = 12;
  localparam int RANDOM_ITEMS = 1600;
  localparam int WORD_MAX     = 8;
  localparam int TAIL_CYCLES  = 8;
  // covers the clearing pass after reset several times over
  localparam int STALL_LIMIT  = 4 * SLOTS;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] matched_id;
    logic            table_full;
  } verdict_t;

  typedef struct packed {
    logic [3:0]                      len;
    logic [WORD_MAX-1:0][CHAR_W-1:0] text;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tkm_in_if  keys();
  tkm_out_if results();

  trie_keyword_matcher dut (
    .clk     (clk),
    .rst     (rst),
    .keys    (keys),
    .results (results)
  );

  // shadow trie
  node_t       trie_child [SLOTS];
  key_t        node_tag [NODES];
  int unsigned alloc_top;
  int unsigned cursor;
  logic        broken;

  verdict_t pending_verdicts[$];
  word_t    stored_words[$];
  int       errors      = 0;
  int       items_sent  = 0;
  int       idle_cycles = 0;
  logic     steady      = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  task automatic clear_trie();
    foreach (trie_child[i]) trie_child[i] = '0;
    foreach (node_tag[i]) node_tag[i] = '0;
    alloc_top = 0;
    cursor    = 0;
    broken    = 1'b0;
  endtask

  // advance the shadow trie by one character; queue a verdict on the last one
  task automatic trie_step(input logic cmd, input logic [CHAR_W-1:0] ch, input logic last,
                           input logic [ID_W-1:0] id);
    int unsigned slot;
    verdict_t    v;
    if (!broken) begin
      if (ch >= ALPHABET) begin
        broken = 1'b1;
      end else begin
        slot = cursor * ALPHABET + ch;
        if (trie_child[slot] != '0) begin
          cursor = trie_child[slot];
        end else if (cmd == CMD_INSERT && alloc_top + 1 < NODES) begin
          alloc_top++;
          trie_child[slot] = node_t'(alloc_top);
          cursor = alloc_top;
        end else begin
          broken = 1'b1;
        end
      end
    end
    if (last) begin
      v = '0;
      if (cmd == CMD_INSERT) begin
        v.table_full = broken;
        if (!broken) node_tag[cursor] = {1'b1, id};
      end else if (!broken && node_tag[cursor][ID_W]) begin
        v.found      = 1'b1;
        v.matched_id = node_tag[cursor][ID_W-1:0];
      end
      pending_verdicts.push_back(v);
      cursor = 0;
      broken = 1'b0;
    end
  endtask

  task automatic send_char(input logic cmd, input logic [CHAR_W-1:0] ch, input logic last,
                           input logic [ID_W-1:0] id);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      keys.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    keys.valid  <= 1'b1;
    keys.cmd    <= cmd;
    keys.ch     <= ch;
    keys.last   <= last;
    keys.key_id <= id;
    do @(posedge clk); while (keys.ready !== 1'b1);
    trie_step(cmd, ch, last, id);
    items_sent++;
  endtask

  task automatic send_word(input logic cmd, input word_t w, input logic [ID_W-1:0] id);
    for (int i = 0; i < w.len; i++) send_char(cmd, w.text[i], i == w.len - 1, id);
    if (cmd == CMD_INSERT) stored_words.push_back(w);
  endtask

  function automatic word_t word_of(input int n, input logic [CHAR_W-1:0] c0,
                                    input logic [CHAR_W-1:0] c1);
    word_t w;
    w         = '0;
    w.len     = 4'(n);
    w.text[0] = c0;
    w.text[1] = c1;
    return w;
  endfunction

  // mostly a three-letter pool so keys share prefixes; now and then any byte
  function automatic word_t random_word();
    word_t w;
    w     = '0;
    w.len = 4'($urandom_range(1, ($urandom_range(0, 9) == 0) ? WORD_MAX : 4));
    for (int i = 0; i < WORD_MAX; i++)
      w.text[i] = ($urandom_range(0, 9) == 0) ? CHAR_W'($urandom)
                                              : CHAR_W'($urandom_range(0, 2));
    return w;
  endfunction

  task automatic drain();
    keys.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(CMD_INSERT, word_of(1, 8'd0, 8'd0), 8'hFF);
    send_word(CMD_INSERT, word_of(2, 8'd127, 8'd1), 8'h00);
    send_word(CMD_MATCH, word_of(1, 8'd0, 8'd0), 8'h00);
    send_word(CMD_MATCH, word_of(2, 8'd127, 8'd1), 8'hFF);
    // prefix of a stored key carries no id
    send_word(CMD_MATCH, word_of(1, 8'd127, 8'd0), 8'h00);
    send_word(CMD_MATCH, word_of(1, 8'd200, 8'd0), 8'h00);
    // out-of-alphabet characters break an insert
    send_word(CMD_INSERT, word_of(1, 8'd128, 8'd0), 8'h11);
    send_word(CMD_INSERT, word_of(2, 8'd1, 8'd255), 8'h22);
    send_word(CMD_MATCH, word_of(2, 8'd5, 8'd6), 8'h00);
    // overwrite the id of a stored key
    send_word(CMD_INSERT, word_of(1, 8'd0, 8'd0), 8'h5A);
    send_word(CMD_MATCH, word_of(1, 8'd0, 8'd0), 8'h00);
    // commands mixed within one key share the cursor
    send_char(CMD_MATCH, 8'd127, 1'b0, 8'h00);
    send_char(CMD_INSERT, 8'd2, 1'b1, 8'h33);
    send_char(CMD_INSERT, 8'd127, 1'b0, 8'h00);
    send_char(CMD_MATCH, 8'd2, 1'b1, 8'h00);
    // once broken, the rest of the key is skipped under either command
    send_char(CMD_MATCH, 8'd9, 1'b0, 8'h00);
    send_char(CMD_INSERT, 8'd1, 1'b1, 8'h77);
    send_char(CMD_INSERT, 8'd130, 1'b0, 8'h00);
    send_char(CMD_MATCH, 8'd0, 1'b1, 8'h00);
  endtask

  task automatic test_random_keys();
    word_t           w;
    logic            cmd;
    logic [ID_W-1:0] id;
    int              pick;
    int              start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 7) == 0);
      cmd    = ($urandom_range(0, 9) < 4) ? CMD_INSERT : CMD_MATCH;
      id     = ID_W'($urandom);
      w      = random_word();
      if (stored_words.size() != 0) begin
        if (cmd == CMD_MATCH && $urandom_range(0, 2) != 0) begin
          w    = stored_words[$urandom_range(0, stored_words.size() - 1)];
          pick = $urandom_range(0, 5);
          if (pick == 0 && w.len > 1) begin
            w.len = w.len - 1;
          end else if (pick == 1 && w.len < WORD_MAX) begin
            w.text[w.len] = CHAR_W'($urandom_range(0, 2));
            w.len = w.len + 1;
          end
        end else if (cmd == CMD_INSERT && $urandom_range(0, 4) == 0) begin
          w = stored_words[$urandom_range(0, stored_words.size() - 1)];
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        for (int i = 0; i < w.len; i++)
          send_char(1'($urandom_range(0, 1)), w.text[i], i == w.len - 1, id);
      end else begin
        send_word(cmd, w, id);
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_table_exhaustion();
    word_t w;
    while (alloc_top + 1 < NODES) begin
      w     = '0;
      w.len = 4'(WORD_MAX);
      for (int i = 0; i < WORD_MAX; i++) w.text[i] = CHAR_W'($urandom_range(64, 127));
      send_word(CMD_INSERT, w, ID_W'($urandom));
    end
    send_word(CMD_INSERT, w, ID_W'($urandom));
    w.text[WORD_MAX-1] = w.text[WORD_MAX-1] ^ 8'h01;
    send_word(CMD_INSERT, w, ID_W'($urandom));
    send_word(CMD_MATCH, w, 8'h00);
    // existing paths still take a new id with no node left
    send_word(CMD_INSERT, stored_words[0], 8'hC3);
    send_word(CMD_MATCH, stored_words[0], 8'h00);
    send_word(CMD_MATCH, stored_words[stored_words.size() - 1], 8'h00);
  endtask

  initial begin : result_checker
    verdict_t want;
    int       stall;
    results.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        results.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (results.valid !== 1'b1);
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: found %0b, matched_id %0d, table_full %0b",
               results.found, results.matched_id, results.table_full);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (results.found !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, results.found);
          errors++;
        end
        if (results.matched_id !== want.matched_id) begin
          $error("matched_id: expected %0d, actual %0d", want.matched_id, results.matched_id);
          errors++;
        end
        if (results.table_full !== want.table_full) begin
          $error("table_full: expected %0b, actual %0b", want.table_full, results.table_full);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((keys.valid === 1'b1 && keys.ready === 1'b1) ||
        (results.valid === 1'b1 && results.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    keys.valid  <= 1'b0;
    keys.cmd    <= CMD_INSERT;
    keys.ch     <= '0;
    keys.last   <= 1'b0;
    keys.key_id <= '0;
    clear_trie();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    drain();
    test_random_keys();
    drain();
    test_table_exhaustion();
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tkm_pkg.sv
sv/tkm_in_if.sv
sv/tkm_out_if.sv
sv/tkm_ctrl.sv
sv/tkm_datapath.sv
sv/trie_keyword_matcher.sv
sim/trie_keyword_matcher_tb.sv
